@@ hw/rtl/fedl_pkg.sv @@
// Shared types and constants for the feedback echo delay line.
package fedl_pkg;

    localparam int TARGET_W  = 33;   // widest target register, 16 fraction bits
    localparam int GAIN_W    = 17;   // Q16 gain, 65536 = 1.0
    localparam int STEPS_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [TARGET_W-1:0] RESET_DELAY = 33'd1572864000;
    localparam logic [STEPS_W-1:0]  RESET_STEPS = 16'd2400;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO   = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_INTERP,
        ST_DELAY,
        ST_GAIN,
        ST_WRITE
    } seq_state_t;

    // per-cycle commands from the sequencer to both lanes
    typedef struct packed {
        logic load;     // capture the input sample
        logic rd;       // read both interpolation taps
        logic mul;      // tap difference times fraction
        logic dly;      // form the delayed sample
        logic gain;     // feedback and mix products
        logic wr;       // ring write
        logic clear;    // ring write of zero during the sweep after reset
    } lane_ctrl_t;

endpackage

@@ hw/rtl/feedback_echo_delay_line.sv @@
// An accepted word steps through the address, read, interpolate, delay, gain and write
// states; the write state waits for a free output stage. Only idle takes a new word, and
// the sequencer runs one sample through both lanes. A target write that changes a target
// with a nonzero ramp length holds s_axis_tready low while the serial divider forms the
// ramp increment. Reset: control clears at once; then a sweep over all ring positions
// zeroes both rings, with s_axis_tready low. Configuration writes are taken throughout.
module feedback_echo_delay_line #(
    parameter int MAX_DELAY   = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // left_in, right_in, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // left_out, right_out, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            m_axis_tdata,
    input  logic                                          cfg_we,
    input  logic [fedl_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [fedl_pkg::TARGET_W-1:0]                 cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_DELAY);
    localparam int TW = fedl_pkg::TARGET_W;
    localparam int GW = fedl_pkg::GAIN_W;
    localparam int FW = fedl_pkg::FRAC_W;
    localparam int CW = (AW + FW > TW) ? AW + FW : TW;

    localparam logic [AW-1:0]   LAST_POS = AW'(MAX_DELAY - 1);
    localparam logic [AW:0]     DEPTH    = (AW + 1)'(MAX_DELAY);
    localparam logic [CW-1:0]   LO_LIM   = CW'(33'h0_0001_0000);
    localparam logic [CW-1:0]   HI_LIM   = CW'({LAST_POS, {FW{1'b0}}});

    fedl_pkg::seq_state_t state_reg, state_next;
    fedl_pkg::lane_ctrl_t ctrl;

    logic [fedl_pkg::STEPS_W-1:0] steps_reg, steps_next;
    logic                         stereo_reg, stereo_next;
    logic [AW-1:0]                wp_reg, wp_next;
    logic [AW-1:0]                ia_reg, ia_next;
    logic [AW-1:0]                ib_reg, ib_next;
    logic [FW-1:0]                frac_reg, frac_next;

    logic [2:0]                   tgt_we;
    logic [TW-1:0]                fb_value;
    logic [TW-1:0]                mix_value;
    logic [TW-1:0]                delay_now;
    logic [TW-1:0]                fb_now;
    logic [TW-1:0]                mix_now;
    logic [2:0]                   ramp_busy;
    logic                         accept;
    logic                         out_load;
    logic                         out_free;
    logic                         wp_step;

    logic [CW-1:0]                dly;
    logic [AW-1:0]                d_int;
    logic [AW:0]                  pos_diff;
    logic [AW:0]                  pos_wrap;

    logic signed [SB-1:0]         left_res;
    logic signed [SB-1:0]         right_res;

    // configuration port
    always_comb
    begin
        tgt_we      = '0;
        steps_next  = steps_reg;
        stereo_next = stereo_reg;
        fb_value    = TW'(cfg_data[GW-1:0]);
        mix_value   = TW'(cfg_data[GW-1:0]);
        if (cfg_we)
        begin
            unique case (cfg_index)
                fedl_pkg::CFG_DELAY:    tgt_we[0]   = 1'b1;
                fedl_pkg::CFG_FEEDBACK: tgt_we[1]   = 1'b1;
                fedl_pkg::CFG_MIX:      tgt_we[2]   = 1'b1;
                fedl_pkg::CFG_STEPS:    steps_next  = cfg_data[fedl_pkg::STEPS_W-1:0];
                fedl_pkg::CFG_STEREO:   stereo_next = cfg_data[0];
                default:                tgt_we      = '0;
            endcase
        end
    end

    fedl_ramp #(
        .RESET_VALUE (fedl_pkg::RESET_DELAY)
    ) u_ramp_delay (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tgt_we[0]),
        .wr_value (cfg_data),
        .steps    (steps_reg),
        .advance  (accept),
        .now_val  (delay_now),
        .busy     (ramp_busy[0])
    );

    fedl_ramp #(
        .RESET_VALUE (33'd0)
    ) u_ramp_fb (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tgt_we[1]),
        .wr_value (fb_value),
        .steps    (steps_reg),
        .advance  (accept),
        .now_val  (fb_now),
        .busy     (ramp_busy[1])
    );

    fedl_ramp #(
        .RESET_VALUE (33'd0)
    ) u_ramp_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tgt_we[2]),
        .wr_value (mix_value),
        .steps    (steps_reg),
        .advance  (accept),
        .now_val  (mix_now),
        .busy     (ramp_busy[2])
    );

    // tap addresses from the clamped delay
    always_comb
    begin
        priority if (CW'(delay_now) < LO_LIM)
            dly = LO_LIM;
        else if (CW'(delay_now) > HI_LIM)
            dly = HI_LIM;
        else
            dly = CW'(delay_now);
        d_int     = dly[AW+FW-1:FW];
        frac_next = dly[FW-1:0];
        pos_diff  = {1'b0, wp_reg} - {1'b0, d_int};
        pos_wrap  = pos_diff[AW] ? pos_diff + DEPTH : pos_diff;
        ia_next   = pos_wrap[AW-1:0];
        ib_next   = (ia_next == '0) ? LAST_POS : ia_next - 1'b1;
        wp_next   = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fedl_pkg::ST_CLEAR:  if (wp_reg == LAST_POS) state_next = fedl_pkg::ST_IDLE;
            fedl_pkg::ST_IDLE:   if (accept) state_next = fedl_pkg::ST_ADDR;
            fedl_pkg::ST_ADDR:   state_next = fedl_pkg::ST_READ;
            fedl_pkg::ST_READ:   state_next = fedl_pkg::ST_INTERP;
            fedl_pkg::ST_INTERP: state_next = fedl_pkg::ST_DELAY;
            fedl_pkg::ST_DELAY:  state_next = fedl_pkg::ST_GAIN;
            fedl_pkg::ST_GAIN:   state_next = fedl_pkg::ST_WRITE;
            fedl_pkg::ST_WRITE:  if (out_free) state_next = fedl_pkg::ST_IDLE;
            default:             state_next = fedl_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ctrl          = '0;
        out_load      = 1'b0;
        wp_step       = 1'b0;
        unique case (state_reg)
            fedl_pkg::ST_CLEAR:
            begin
                ctrl.wr    = 1'b1;
                ctrl.clear = 1'b1;
                wp_step    = 1'b1;
            end
            fedl_pkg::ST_IDLE:
            begin
                s_axis_tready = (ramp_busy == '0);
                ctrl.load     = 1'b1;
            end
            fedl_pkg::ST_READ:   ctrl.rd   = 1'b1;
            fedl_pkg::ST_INTERP: ctrl.mul  = 1'b1;
            fedl_pkg::ST_DELAY:  ctrl.dly  = 1'b1;
            fedl_pkg::ST_GAIN:   ctrl.gain = 1'b1;
            fedl_pkg::ST_WRITE:
            begin
                ctrl.wr  = out_free;
                out_load = out_free;
                wp_step  = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fedl_pkg::ST_CLEAR;
            steps_reg  <= fedl_pkg::RESET_STEPS;
            stereo_reg <= 1'b1;
            wp_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            steps_reg  <= steps_next;
            stereo_reg <= stereo_next;
            if (wp_step)
                wp_reg <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fedl_pkg::ST_ADDR)
        begin
            ia_reg   <= ia_next;
            ib_reg   <= ib_next;
            frac_reg <= frac_next;
        end
    end

    fedl_lane #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk       (clk),
        .ctrl      (ctrl),
        .active    (1'b1),
        .sample    ($signed(s_axis_tdata[SB-1:0])),
        .rd_addr_a (ia_reg),
        .rd_addr_b (ib_reg),
        .wr_addr   (wp_reg),
        .frac      (frac_reg),
        .fb_gain   (fb_now[GW-1:0]),
        .mix_gain  (mix_now[GW-1:0]),
        .result    (left_res)
    );

    // right lane passes its input through when stereo is off
    fedl_lane #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk       (clk),
        .ctrl      (ctrl),
        .active    (stereo_reg),
        .sample    ($signed(s_axis_tdata[2*SB-1:SB])),
        .rd_addr_a (ia_reg),
        .rd_addr_b (ib_reg),
        .wr_addr   (wp_reg),
        .frac      (frac_reg),
        .fb_gain   (fb_now[GW-1:0]),
        .mix_gain  (mix_now[GW-1:0]),
        .result    (right_res)
    );

    fedl_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .left          (left_res),
        .right         (right_res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ hw/rtl/fedl_ramp.sv @@
// One smoothed parameter: target, current value, ramp step and serial divider.
module fedl_ramp #(
    parameter logic [fedl_pkg::TARGET_W-1:0] RESET_VALUE = 33'd0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [fedl_pkg::TARGET_W-1:0]    wr_value,
    input  logic [fedl_pkg::STEPS_W-1:0]     steps,
    input  logic                             advance,
    output logic [fedl_pkg::TARGET_W-1:0]    now_val,
    output logic                             busy
);

    localparam int TW     = fedl_pkg::TARGET_W;
    localparam int SW     = fedl_pkg::STEPS_W;
    localparam int IW     = TW + 1;              // signed increment
    localparam int CNT_W  = $clog2(TW + 1);

    logic [TW-1:0]        target_reg, target_next;
    logic [TW-1:0]        now_reg, now_next;
    logic signed [IW-1:0] inc_reg, inc_next;
    logic [SW-1:0]        count_reg, count_next;

    logic                 div_busy_reg, div_busy_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [TW-1:0]        quo_reg, quo_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]        dsr_reg, dsr_next;
    logic                 neg_reg, neg_next;

    logic signed [IW-1:0] diff;
    logic [TW-1:0]        mag;
    logic [SW:0]          trial;
    logic                 qbit;
    logic [TW-1:0]        quo_step;
    logic [IW-1:0]        quo_ext;
    logic signed [IW:0]   sum;

    always_comb
    begin
        diff     = $signed({1'b0, wr_value}) - $signed({1'b0, now_reg});
        mag      = diff[IW-1] ? TW'(-diff) : TW'(diff);
        trial    = {rem_reg, quo_reg[TW-1]};
        qbit     = (trial >= {1'b0, dsr_reg});
        quo_step = {quo_reg[TW-2:0], qbit};
        quo_ext  = {1'b0, quo_step};
        sum      = $signed({2'b00, now_reg}) + $signed({inc_reg[IW-1], inc_reg});

        target_next   = target_reg;
        now_next      = now_reg;
        inc_next      = inc_reg;
        count_next    = count_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        neg_next      = neg_reg;

        priority if (wr_en)
        begin
            if (wr_value != target_reg)
            begin
                target_next = wr_value;
                if (steps == '0)
                begin
                    now_next      = wr_value;
                    count_next    = '0;
                    div_busy_next = 1'b0;
                end
                else
                begin
                    count_next    = steps;
                    div_busy_next = 1'b1;
                    div_cnt_next  = CNT_W'(TW);
                    quo_next      = mag;
                    rem_next      = '0;
                    dsr_next      = steps;
                    neg_next      = diff[IW-1];
                end
            end
        end
        else if (div_busy_reg)
        begin
            // restoring division, one quotient bit a cycle while no write to this target comes in
            rem_next     = qbit ? SW'(trial - {1'b0, dsr_reg}) : trial[SW-1:0];
            quo_next     = quo_step;
            div_cnt_next = div_cnt_reg - 1'b1;
            if (div_cnt_reg == CNT_W'(1))
            begin
                div_busy_next = 1'b0;
                inc_next      = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
            end
        end
        else if (advance)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == SW'(1))
                    now_next = target_reg;
                else
                    now_next = sum[TW-1:0];
            end
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= RESET_VALUE;
            now_reg      <= RESET_VALUE;
            inc_reg      <= '0;
            count_reg    <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            target_reg   <= target_next;
            now_reg      <= now_next;
            inc_reg      <= inc_next;
            count_reg    <= count_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign now_val = now_reg;
    assign busy    = div_busy_reg;

endmodule

@@ hw/rtl/fedl_lane.sv @@
// One channel lane: ring memory, interpolated tap read, feedback and mix gains.
module fedl_lane #(
    parameter int MAX_DELAY   = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  fedl_pkg::lane_ctrl_t                ctrl,
    input  logic                                active,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [$clog2(MAX_DELAY)-1:0]        rd_addr_a,
    input  logic [$clog2(MAX_DELAY)-1:0]        rd_addr_b,
    input  logic [$clog2(MAX_DELAY)-1:0]        wr_addr,
    input  logic [fedl_pkg::FRAC_W-1:0]         frac,
    input  logic [fedl_pkg::GAIN_W-1:0]         fb_gain,
    input  logic [fedl_pkg::GAIN_W-1:0]         mix_gain,
    output logic signed [SAMPLE_BITS-1:0]       result
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + 18;                 // sample times Q16 gain or fraction

    localparam logic signed [SB+2:0] SAT_HI = {4'b0000, {(SB-1){1'b1}}};
    localparam logic signed [SB+2:0] SAT_LO = {4'b1111, {(SB-1){1'b0}}};
    localparam logic signed [PW-1:0] RND    = {{(PW-16){1'b0}}, 16'h8000};

    logic [SB-1:0]          ring [MAX_DELAY];

    logic signed [SB-1:0]   in_reg;
    logic signed [SB-1:0]   a_reg;
    logic signed [SB-1:0]   b_reg;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [SB-1:0]   dly_reg, dly_next;
    logic signed [PW-1:0]   fbp_reg, fbp_next;
    logic signed [PW-1:0]   mxp_reg, mxp_next;

    logic signed [SB:0]     tap_diff;
    logic signed [SB+1:0]   dly_wide;
    logic signed [PW-1:0]   fb_rnd;
    logic signed [PW-1:0]   mx_rnd;
    logic signed [SB+2:0]   fb_sum;
    logic signed [SB+2:0]   mx_sum;
    logic signed [SB-1:0]   wr_data;
    logic                   wr_en;

    function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
        logic signed [SB+2:0] c;
        begin
            priority if (v > SAT_HI)
                c = SAT_HI;
            else if (v < SAT_LO)
                c = SAT_LO;
            else
                c = v;
            sat = c[SB-1:0];
        end
    endfunction

    always_comb
    begin
        tap_diff  = $signed({b_reg[SB-1], b_reg}) - $signed({a_reg[SB-1], a_reg});
        prod_next = tap_diff * $signed({1'b0, frac});
        // arithmetic shift gives the floor of the Q16 product
        dly_wide  = $signed({{2{a_reg[SB-1]}}, a_reg}) + $signed(prod_reg[PW-1:16]);
        dly_next  = dly_wide[SB-1:0];
        fbp_next  = dly_reg * $signed({1'b0, fb_gain});
        mxp_next  = dly_reg * $signed({1'b0, mix_gain});
        fb_rnd    = fbp_reg + RND;
        mx_rnd    = mxp_reg + RND;
        fb_sum    = $signed({{3{in_reg[SB-1]}}, in_reg})
                  + $signed({fb_rnd[PW-1], fb_rnd[PW-1:16]});
        mx_sum    = $signed({{3{in_reg[SB-1]}}, in_reg})
                  + $signed({mx_rnd[PW-1], mx_rnd[PW-1:16]});
        wr_data   = ctrl.clear ? '0 : sat(fb_sum);
        wr_en     = ctrl.wr && (active || ctrl.clear);
        result    = active ? sat(mx_sum) : in_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            in_reg <= sample;
        if (ctrl.mul)
            prod_reg <= prod_next;
        if (ctrl.dly)
            dly_reg <= dly_next;
        if (ctrl.gain)
        begin
            fbp_reg <= fbp_next;
            mxp_reg <= mxp_next;
        end
    end

    // ring: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring[wr_addr] <= wr_data;
        if (ctrl.rd)
        begin
            a_reg <= ring[rd_addr_a];
            b_reg <= ring[rd_addr_b];
        end
    end

endmodule

@@ hw/rtl/fedl_merge.sv @@
// Output stage: packs both lane results into one registered stream word.
module fedl_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          load,
    input  logic signed [SAMPLE_BITS-1:0]                 left,
    input  logic signed [SAMPLE_BITS-1:0]                 right,
    output logic                                          free,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // left_out, right_out, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            m_axis_tdata
);

    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= TDATA_W'({right, left});
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

@@ sim/fedl_echo_checker.sv @@
// Checker for the feedback echo delay line: tracks config, predicts each output word, compares.
`timescale 1ns / 1ps
module fedl_echo_checker #(
    parameter int MAX_DELAY   = 131072,
    parameter int SAMPLE_BITS = 24,
    parameter int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [DATA_W-1:0]              s_axis_tdata,   // left_in, right_in
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [DATA_W-1:0]              m_axis_tdata,   // left_out, right_out
    input  logic                           cfg_we,
    input  logic [fedl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fedl_pkg::TARGET_W-1:0]  cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    localparam longint SAT_HI    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO    = -SAT_HI - 1;
    localparam longint Q16_ONE   = 65536;
    localparam longint DELAY_MIN = Q16_ONE;
    localparam longint DELAY_MAX = longint'(MAX_DELAY - 1) * Q16_ONE;
    localparam int     LEFT      = 0;
    localparam int     RIGHT     = 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef struct {
        sample_t left;
        sample_t right;
    } echo_pair_t;

    sample_t     echo_ring [0:1][0:MAX_DELAY-1];
    int unsigned wr_pos;
    longint      tgt        [0:2];
    longint      level      [0:2];
    longint      slope      [0:2];
    int unsigned steps_left [0:2];
    int unsigned ramp_len;
    logic        stereo_on;

    echo_pair_t  expected_pairs [$];
    echo_pair_t  got;
    echo_pair_t  want;
    int          errs;
    int          queued;

    assign mismatches  = errs;
    assign outstanding = queued;

    function automatic longint clip(input longint v);
        return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
    endfunction

    // Q16 gain, rounded to nearest with ties upward
    function automatic longint q16_scale(input longint x, input longint g);
        return (x * g + 32768) >>> 16;
    endfunction

    task automatic apply_reg(input logic [fedl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fedl_pkg::TARGET_W-1:0] val);
        longint t;
        int     k;
        if (idx == fedl_pkg::CFG_DELAY || idx == fedl_pkg::CFG_FEEDBACK
            || idx == fedl_pkg::CFG_MIX) begin
            k = int'(idx);
            t = (idx == fedl_pkg::CFG_DELAY) ? longint'(val)
                                             : longint'(val[fedl_pkg::GAIN_W-1:0]);
            // rewriting the current target leaves a running ramp alone
            if (t != tgt[k]) begin
                tgt[k] = t;
                if (ramp_len == 0) begin
                    level[k]      = t;
                    steps_left[k] = 0;
                end
                else begin
                    steps_left[k] = ramp_len;
                    slope[k]      = (t - level[k]) / longint'(ramp_len);
                end
            end
        end
        else if (idx == fedl_pkg::CFG_STEPS)
            ramp_len = 32'(val[fedl_pkg::STEPS_W-1:0]);
        else if (idx == fedl_pkg::CFG_STEREO)
            stereo_on = val[0];
    endtask

    function automatic echo_pair_t echo_sample(input sample_t l_in, input sample_t r_in);
        echo_pair_t  res;
        longint      dly;
        longint      frac;
        longint      a;
        longint      b;
        longint      wet;
        longint      dry;
        longint      outv;
        int unsigned whole;
        int unsigned ia;
        int unsigned ib;
        int          k;
        int          lane;
        for (k = 0; k < 3; k++)
            if (steps_left[k] > 0) begin
                steps_left[k]--;
                if (steps_left[k] == 0)
                    level[k] = tgt[k];
                else
                    level[k] += slope[k];
            end
        dly = level[fedl_pkg::CFG_DELAY];
        if (dly < DELAY_MIN)
            dly = DELAY_MIN;
        if (dly > DELAY_MAX)
            dly = DELAY_MAX;
        whole = 32'(dly >> 16);
        frac  = dly & 65535;
        ia    = (wr_pos + MAX_DELAY - whole) % MAX_DELAY;
        ib    = (wr_pos + 2 * MAX_DELAY - whole - 1) % MAX_DELAY;
        for (lane = LEFT; lane <= RIGHT; lane++) begin
            dry = (lane == LEFT) ? longint'(l_in) : longint'(r_in);
            if (lane == RIGHT && !stereo_on)
                outv = dry;
            else begin
                a    = echo_ring[lane][ia];
                b    = echo_ring[lane][ib];
                wet  = a + (((b - a) * frac) >>> 16);
                echo_ring[lane][wr_pos] =
                    sample_t'(clip(dry + q16_scale(wet, level[fedl_pkg::CFG_FEEDBACK])));
                outv = clip(dry + q16_scale(wet, level[fedl_pkg::CFG_MIX]));
            end
            if (lane == LEFT)
                res.left = sample_t'(outv);
            else
                res.right = sample_t'(outv);
        end
        wr_pos = (wr_pos + 1) % MAX_DELAY;
        return res;
    endfunction

    task automatic check_lane(input string name, input sample_t exp_v, input sample_t act_v);
        if (exp_v !== act_v) begin
            errs++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_DELAY; i++) begin
                echo_ring[LEFT][i]  = '0;
                echo_ring[RIGHT][i] = '0;
            end
            wr_pos = 0;
            for (int k = 0; k < 3; k++) begin
                tgt[k]        = 0;
                level[k]      = 0;
                slope[k]      = 0;
                steps_left[k] = 0;
            end
            tgt[fedl_pkg::CFG_DELAY]   = fedl_pkg::RESET_DELAY;
            level[fedl_pkg::CFG_DELAY] = fedl_pkg::RESET_DELAY;
            ramp_len                   = 32'(fedl_pkg::RESET_STEPS);
            stereo_on                  = 1'b1;
            expected_pairs.delete();
            errs   = 0;
            queued = 0;
        end
        else begin
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready) begin
                got.left  = m_axis_tdata[SAMPLE_BITS-1:0];
                got.right = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                if (expected_pairs.size() == 0) begin
                    errs++;
                    $display("%0t: expected no output word, got %0d / %0d",
                             $time, got.left, got.right);
                end
                else begin
                    want = expected_pairs.pop_front();
                    check_lane("left_out", want.left, got.left);
                    check_lane("right_out", want.right, got.right);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pairs.push_back(echo_sample(s_axis_tdata[SAMPLE_BITS-1:0],
                                                     s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
            queued = expected_pairs.size();
        end
    end

endmodule

@@ sim/tb_feedback_echo_delay_line.sv @@
// Testbench top for the feedback echo delay line: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_feedback_echo_delay_line;

    localparam int SAMPLE_BITS     = 24;
    localparam int DATA_W          = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int TW              = fedl_pkg::TARGET_W;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 75;
    localparam int LONG_HOLD       = 400;
    localparam int HOLD_PHASE      = 2;

    localparam logic [TW-1:0] DELAY_MIN_Q16 = 33'd65536;
    localparam logic [TW-1:0] DELAY_MAX_Q16 = 33'd8589869056;
    localparam logic [TW-1:0] GAIN_ONE      = 33'd65536;
    localparam logic [TW-1:0] RAMP_LONGEST  = 33'd65535;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [DATA_W-1:0]              s_axis_tdata;    // left_in, right_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [DATA_W-1:0]              m_axis_tdata;    // left_out, right_out
    logic                           cfg_we;
    logic [fedl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [TW-1:0]                  cfg_data;

    int   mismatches;
    int   outstanding;
    logic idle_on;
    logic sink_hold_req;
    int   words_sent;
    int   settings_seen;
    int   mono_settings;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    feedback_echo_delay_line dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fedl_echo_checker u_echo_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // output side: random stall bursts, plus one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] corner(input int k);
        case (k % 6)
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            4:       return 24'h555555;
            default: return 24'hAAAAAA;
        endcase
    endfunction

    // zeros are common so that echoes ring out on their own
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3:    return '0;
            4, 5:    return SAMPLE_BITS'($urandom_range(0, 511) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // a target write may start the increment divider, which holds tready low
    task automatic write_reg(input logic [fedl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [TW-1:0] val);
        int n;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        n = 0;
        while (s_axis_tready && n < 3) begin
            @(negedge clk);
            n++;
        end
        while (!s_axis_tready) @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_settings();
        logic [TW-1:0] dly;
        logic [TW-1:0] fb;
        logic [TW-1:0] mix;
        logic [TW-1:0] ramp;
        logic          stereo;
        case ($urandom_range(0, 5))
            0:       dly = DELAY_MIN_Q16;
            1:       dly = DELAY_MAX_Q16;
            2:       dly = (TW'($urandom_range(1, 131070)) << 16) | TW'($urandom_range(0, 65535));
            default: dly = (TW'($urandom_range(1, 40)) << 16) | TW'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
            0, 1:    ramp = '0;
            2, 3:    ramp = TW'($urandom_range(1, 8));
            4:       ramp = TW'($urandom_range(9, 300));
            5:       ramp = RAMP_LONGEST;
            default: ramp = 33'd1;
        endcase
        case ($urandom_range(0, 3))
            0:       fb = '0;
            1:       fb = GAIN_ONE;
            default: fb = TW'($urandom_range(0, 58000));
        endcase
        case ($urandom_range(0, 3))
            0:       mix = '0;
            1:       mix = GAIN_ONE;
            default: mix = TW'($urandom_range(0, 65536));
        endcase
        stereo = 1'($urandom_range(0, 1));
        write_reg(fedl_pkg::CFG_STEPS, ramp);
        write_reg(fedl_pkg::CFG_DELAY, dly);
        write_reg(fedl_pkg::CFG_FEEDBACK, fb);
        write_reg(fedl_pkg::CFG_MIX, mix);
        write_reg(fedl_pkg::CFG_STEREO, {32'd0, stereo});
        settings_seen++;
        if (!stereo)
            mono_settings++;
    endtask

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = fedl_pkg::CFG_DELAY;
        cfg_data      = '0;
        idle_on       = 1'b0;
        sink_hold_req = 1'b0;
        words_sent    = 0;
        settings_seen = 0;
        mono_settings = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // wait out the ring sweep
        while (!s_axis_tready) @(negedge clk);

        // unity feedback and mix at the shortest delay: full-scale words saturate
        idle_on = 1'b1;
        write_reg(fedl_pkg::CFG_STEPS, '0);
        write_reg(fedl_pkg::CFG_DELAY, DELAY_MIN_Q16);
        write_reg(fedl_pkg::CFG_FEEDBACK, GAIN_ONE);
        write_reg(fedl_pkg::CFG_MIX, GAIN_ONE);
        write_reg(fedl_pkg::CFG_STEREO, 33'd1);
        settings_seen++;
        for (int i = 0; i < 12; i++)
            send_word(corner(i), corner(i + 3));
        drain();

        // mono pass-through with a delay of one and a half samples
        write_reg(fedl_pkg::CFG_STEREO, '0);
        write_reg(fedl_pkg::CFG_DELAY, 33'd98304);
        write_reg(fedl_pkg::CFG_FEEDBACK, 33'd32768);
        write_reg(fedl_pkg::CFG_STEPS, 33'd5);
        settings_seen++;
        mono_settings++;
        for (int i = 0; i < 6; i++)
            send_word(corner(i + 1), corner(i));
        drain();

        // same target again is ignored; a new one ramps, and a later length change
        // leaves that ramp running
        write_reg(fedl_pkg::CFG_DELAY, 33'd98304);
        write_reg(fedl_pkg::CFG_DELAY, 33'd294912);
        write_reg(fedl_pkg::CFG_STEPS, '0);
        write_reg(fedl_pkg::CFG_STEREO, 33'd1);
        settings_seen++;
        for (int i = 0; i < 7; i++)
            send_word(corner(i), corner(5 - i));
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            random_settings();
            idle_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (phase == HOLD_PHASE) begin
                // sender keeps offering while the output is held off
                idle_on       = 1'b0;
                sink_hold_req = 1'b1;
            end
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_word(pick_sample(), pick_sample());
            drain();
        end

        $display("Summary: %0d sample words over %0d parameter settings, %0d of them mono",
                 words_sent, settings_seen, mono_settings);
        $display("  incl. jumps and ramps, both delay limits, unity gains, a %0d-cycle output hold",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("PASS feedback_echo_delay_line");
        else
            $display("FAIL feedback_echo_delay_line");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL feedback_echo_delay_line");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fedl_pkg.sv
hw/rtl/fedl_ramp.sv
hw/rtl/fedl_lane.sv
hw/rtl/fedl_merge.sv
hw/rtl/feedback_echo_delay_line.sv
sim/fedl_echo_checker.sv
sim/tb_feedback_echo_delay_line.sv
